// File: hdl/clw_pkg.sv
// Package for the character-LCD text-to-bus writer.
// Holds field widths, request and register codes, and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clw_pkg;

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W = 2;
  localparam int COL_W = 6;
  localparam int COL_DEPTH = 1 << COL_W;
  localparam int ROWS_W = 3;
  localparam int ADDR_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 6;

  localparam int TAB_STOP_DEF = 4;
  localparam int COLUMN_LIMIT_DEF = 63;
  localparam int MAX_RESULTS = 24;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BREAK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END = 3'd4;

  localparam logic RST_FOUR_BIT = 1'b1;
  localparam logic [ROWS_W-1:0] RST_ROWS = 3'd2;
  localparam logic [COL_W-1:0] RST_COLUMNS = 6'd16;
  localparam logic [COL_W-1:0] RST_ROW_BREAK = 6'd16;
  localparam logic [COL_W-1:0] RST_LINE_END = 6'd16;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CMD_CLEAR = 8'h01;
  localparam logic [CHAR_W-1:0] CMD_SET_ADDR = 8'h80;

  localparam logic [1:0] BSRC_DATA = 2'd0;
  localparam logic [1:0] BSRC_CLEAR = 2'd1;
  localparam logic [1:0] BSRC_ADDR = 2'd2;

  localparam logic [1:0] GSRC_TARGET = 2'd0;
  localparam logic [1:0] GSRC_NEWLINE = 2'd1;
  localparam logic [1:0] GSRC_CURSOR = 2'd2;

  typedef struct packed {
    logic       start;
    logic       byte_load;
    logic [1:0] byte_src;
    logic       push;
    logic       nib_lo;
    logic       flush;
    logic       col_adv;
    logic       goto_load;
    logic [1:0] goto_src;
    logic       div_start;
    logic       cursor_set;
    logic       cursor_clear;
  } clw_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_nl;
    logic              is_tab;
    logic              four_bit;
    logic              tx_ready;
    logic              div_busy;
    logic              need_div;
    logic              split;
    logic              wrap_hit;
    logic              tab_aligned;
  } clw_sts_t;

endpackage

`default_nettype wire

// File: hdl/clw_in_if.sv
// Request channel interface: valid/ready handshake with the request fields.
// Depends on clw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface clw_in_if import clw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  target_row;
  logic [COL_W-1:0]  target_col;

  modport source (output valid, output kind, output char_code, output target_row,
                  output target_col, input ready);
  modport sink (input valid, input kind, input char_code, input target_row,
                input target_col, output ready);
endinterface

`default_nettype wire

// File: hdl/clw_out_if.sv
// Bus-transfer channel interface: valid/ready handshake with one LCD bus transfer.
// Depends on clw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface clw_out_if import clw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              register_select;
  logic [CHAR_W-1:0] bus_value;
  logic              last;

  modport source (output valid, output register_select, output bus_value, output last,
                  input ready);
  modport sink (input valid, input register_select, input bus_value, input last,
                output ready);
endinterface

`default_nettype wire

// File: hdl/clw_divider.sv
// Restoring remainder unit, one quotient bit per cycle, for the address layouts.
// Depends on clw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clw_divider import clw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [COL_W-1:0] dividend,
  input  logic [COL_W-1:0] divisor,
  output logic             busy,
  output logic [COL_W-1:0] rem
);

  localparam int STEP_W = $clog2(COL_W);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [COL_W-1:0]  rem_r, rem_nxt;
  logic [COL_W-1:0]  dvd_r, dvd_nxt;
  logic [COL_W-1:0]  dsr_r, dsr_nxt;
  logic [COL_W:0]    shifted;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r, dvd_r[COL_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(COL_W - 1);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[COL_W-2:0], 1'b0};
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = COL_W'(shifted - {1'b0, dsr_r});
      end else begin
        rem_nxt = shifted[COL_W-1:0];
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  // A zero divisor subtracts nothing, so the dividend shifts whole into the remainder.
  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: hdl/clw_tx_stage.sv
// Transfer output stage: a one-deep hold stage that tags the final transfer, then the
// output register. Counts transfers per request and drops those beyond the limit.
// Depends on clw_pkg and clw_out_if.
`timescale 1ns / 1ps
`default_nettype none

module clw_tx_stage import clw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              push,
  input  logic              push_rs,
  input  logic [CHAR_W-1:0] push_val,
  input  logic              flush,
  output logic              tx_ready,
  clw_out_if.source         out_chan
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

  logic              pend_valid_r;
  logic              pend_rs_r;
  logic [CHAR_W-1:0] pend_val_r;
  logic              out_valid_r;
  logic              out_rs_r;
  logic [CHAR_W-1:0] out_val_r;
  logic              out_last_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_free;
  logic              push_eff;
  logic              flush_eff;
  logic              move;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign tx_ready  = !pend_valid_r || out_free;
  assign push_eff  = push && tx_ready && (cnt_r < CNT_MAX);
  assign flush_eff = flush && tx_ready;
  assign move      = pend_valid_r && out_free && (push_eff || flush_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (push_eff) begin
        pend_valid_r <= 1'b1;
      end else if (flush_eff) begin
        pend_valid_r <= 1'b0;
      end
      if (clear) begin
        cnt_r <= '0;
      end else if (push_eff) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
    if (move) begin
      out_rs_r   <= pend_rs_r;
      out_val_r  <= pend_val_r;
      out_last_r <= flush_eff;
    end
    if (push_eff) begin
      pend_rs_r  <= push_rs;
      pend_val_r <= push_val;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.register_select = out_rs_r;
  assign out_chan.bus_value       = out_val_r;
  assign out_chan.last            = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("transfer count passed its limit");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (flush && tx_ready && pend_valid_r) |=> (out_chan.valid && out_chan.last))
    else $error("flushed transfer not presented as final");

  a_push_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_eff && pend_valid_r && !flush) |=> (out_chan.valid && !out_chan.last))
    else $error("displaced transfer marked final");

  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    push_eff |=> pend_valid_r)
    else $error("accepted transfer lost from hold stage");
`endif

endmodule

`default_nettype wire

// File: hdl/clw_datapath.sv
// Datapath: configuration registers, request and cursor registers, address layouts,
// remainder unit and transfer output stage. Depends on clw_pkg, clw_divider,
// clw_tx_stage and clw_out_if.
`timescale 1ns / 1ps
`default_nettype none

module clw_datapath import clw_pkg::*; #(
  parameter int TAB_STOP     = TAB_STOP_DEF,
  parameter int COLUMN_LIMIT = COLUMN_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clw_cmd_t              cmd,
  output clw_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [ROW_W-1:0]      in_target_row,
  input  logic [COL_W-1:0]      in_target_col,
  clw_out_if.source             out_chan
);

  localparam logic [COL_W:0] COL_LIM = (COL_W + 1)'(COLUMN_LIMIT);

  logic              four_bit_r;
  logic [ROWS_W-1:0] rows_r;
  logic [COL_W-1:0]  cols_r;
  logic [COL_W-1:0]  row_break_r;
  logic [COL_W-1:0]  line_end_r;

  logic [KIND_W-1:0] kind_r;
  logic [CHAR_W-1:0] char_r;
  logic [ROW_W-1:0]  trow_r;
  logic [COL_W-1:0]  tcol_r;

  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  g_row_r;
  logic [COL_W-1:0]  g_col_r;
  logic [CHAR_W-1:0] byte_r;
  logic              rs_r;

  logic [ROWS_W-1:0] nl_sum;
  logic [ROW_W-1:0]  nl_row;
  logic [COL_W:0]    col_sum;
  logic [COL_W-1:0]  col_next;
  logic              split;
  logic              four_row;
  logic              is_tab;
  logic              quot_nz;
  logic [COL_W-1:0]  div_rem;
  logic              div_busy;
  logic [ADDR_W-1:0] addr;
  logic [CHAR_W-1:0] push_val;
  logic              tx_ready;
  logic [COL_DEPTH-1:0] tab_mask;

  for (genvar gi = 0; gi < COL_DEPTH; gi++) begin : g_tab
    assign tab_mask[gi] = ((gi % TAB_STOP) == 0);
  end

  assign split    = row_break_r > line_end_r;
  assign four_row = rows_r == ROWS_W'(4);
  assign is_tab   = char_r == CHAR_TAB;
  assign nl_sum   = {1'b0, cur_row_r} + ROWS_W'(1);
  assign nl_row   = (nl_sum == rows_r) ? '0 : nl_sum[ROW_W-1:0];
  assign col_sum  = {1'b0, cur_col_r} + (COL_W + 1)'(1);
  assign col_next = (col_sum > COL_LIM) ? '0 : col_sum[COL_W-1:0];
  assign quot_nz  = (line_end_r == '0) || (g_col_r >= line_end_r);

  always_comb begin
    if (split) begin
      addr = {quot_nz, div_rem};
    end else if (four_row) begin
      addr = {g_row_r[0], {COL_W{1'b0}}} + (g_row_r[1] ? {1'b0, row_break_r} : '0)
             + {1'b0, div_rem};
    end else begin
      addr = {(g_row_r != '0), g_col_r};
    end
  end

  always_comb begin
    if (!four_bit_r) begin
      push_val = byte_r;
    end else if (cmd.nib_lo) begin
      push_val = {4'b0, byte_r[3:0]};
    end else begin
      push_val = {4'b0, byte_r[7:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r  <= RST_FOUR_BIT;
      rows_r      <= RST_ROWS;
      cols_r      <= RST_COLUMNS;
      row_break_r <= RST_ROW_BREAK;
      line_end_r  <= RST_LINE_END;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FOUR_BIT:  four_bit_r  <= cfg_data[0];
          CFG_ROWS:      rows_r      <= cfg_data[ROWS_W-1:0];
          CFG_COLUMNS:   cols_r      <= cfg_data[COL_W-1:0];
          CFG_ROW_BREAK: row_break_r <= cfg_data[COL_W-1:0];
          CFG_LINE_END:  line_end_r  <= cfg_data[COL_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.cursor_clear) begin
        cur_row_r <= '0;
        cur_col_r <= '0;
      end else if (cmd.cursor_set) begin
        cur_row_r <= g_row_r;
        cur_col_r <= g_col_r;
      end else if (cmd.col_adv) begin
        cur_col_r <= col_next;
      end
    end
    if (cmd.start) begin
      kind_r <= in_kind;
      char_r <= in_char_code;
      trow_r <= in_target_row;
      tcol_r <= in_target_col;
    end
    if (cmd.goto_load) begin
      case (cmd.goto_src)
        GSRC_TARGET: begin
          g_row_r <= trow_r;
          g_col_r <= tcol_r;
        end
        GSRC_NEWLINE: begin
          g_row_r <= nl_row;
          g_col_r <= '0;
        end
        GSRC_CURSOR: begin
          g_row_r <= cur_row_r;
          g_col_r <= cur_col_r;
        end
        default: begin
          g_row_r <= cur_row_r;
          g_col_r <= cur_col_r;
        end
      endcase
    end
    if (cmd.byte_load) begin
      case (cmd.byte_src)
        BSRC_DATA: begin
          byte_r <= is_tab ? CHAR_SPACE : char_r;
          rs_r   <= 1'b1;
        end
        BSRC_CLEAR: begin
          byte_r <= CMD_CLEAR;
          rs_r   <= 1'b0;
        end
        BSRC_ADDR: begin
          byte_r <= CMD_SET_ADDR | {1'b0, addr};
          rs_r   <= 1'b0;
        end
        default: begin
          byte_r <= byte_r;
          rs_r   <= rs_r;
        end
      endcase
    end
  end

  clw_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (g_col_r),
    .divisor  (split ? line_end_r : row_break_r),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  clw_tx_stage u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cmd.start),
    .push     (cmd.push),
    .push_rs  (rs_r),
    .push_val (push_val),
    .flush    (cmd.flush),
    .tx_ready (tx_ready),
    .out_chan (out_chan)
  );

  always_comb begin
    sts.kind        = kind_r;
    sts.is_nl       = char_r == CHAR_NEWLINE;
    sts.is_tab      = is_tab;
    sts.four_bit    = four_bit_r;
    sts.tx_ready    = tx_ready;
    sts.div_busy    = div_busy;
    sts.need_div    = split || four_row;
    sts.split       = split;
    sts.wrap_hit    = col_next == cols_r;
    sts.tab_aligned = tab_mask[cur_col_r];
  end

endmodule

`default_nettype wire

// File: hdl/clw_ctrl.sv
// Controller state machine: sequences each request into bus transfers, cursor moves
// and address commands. Depends on clw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clw_ctrl import clw_pkg::*; #(
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  clw_sts_t sts,
  output clw_cmd_t cmd
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
  localparam logic [ST_W-1:0] S_DECODE    = 4'd1;
  localparam logic [ST_W-1:0] S_PUT       = 4'd2;
  localparam logic [ST_W-1:0] S_SEND_HI   = 4'd3;
  localparam logic [ST_W-1:0] S_SEND_LO   = 4'd4;
  localparam logic [ST_W-1:0] S_PUT_ADV   = 4'd5;
  localparam logic [ST_W-1:0] S_PUT_SPLIT = 4'd6;
  localparam logic [ST_W-1:0] S_TAB_CHK   = 4'd7;
  localparam logic [ST_W-1:0] S_GOTO      = 4'd8;
  localparam logic [ST_W-1:0] S_GOTO_DIV  = 4'd9;
  localparam logic [ST_W-1:0] S_GOTO_ADDR = 4'd10;
  localparam logic [ST_W-1:0] S_FINISH    = 4'd11;

  localparam int N_W = $clog2(TAB_STOP + 1);
  localparam logic [N_W-1:0] TAB_N = N_W'(TAB_STOP);

  logic [ST_W-1:0] state_r, state_nxt;
  logic [ST_W-1:0] send_ret_r, send_ret_nxt;
  logic [ST_W-1:0] goto_ret_r, goto_ret_nxt;
  logic [N_W-1:0]  n_r, n_nxt;
  logic            tab_more;

  assign tab_more = sts.is_tab && !sts.tab_aligned && (n_r < TAB_N);
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt    = state_r;
    send_ret_nxt = send_ret_r;
    goto_ret_nxt = goto_ret_r;
    n_nxt        = n_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_PUT: begin
            if (sts.is_nl) begin
              cmd.goto_load = 1'b1;
              cmd.goto_src  = GSRC_NEWLINE;
              goto_ret_nxt  = S_FINISH;
              state_nxt     = S_GOTO;
            end else begin
              n_nxt     = '0;
              state_nxt = S_PUT;
            end
          end
          KIND_MOVE: begin
            cmd.goto_load = 1'b1;
            cmd.goto_src  = GSRC_TARGET;
            goto_ret_nxt  = S_FINISH;
            state_nxt     = S_GOTO;
          end
          KIND_CLEAR: begin
            cmd.byte_load    = 1'b1;
            cmd.byte_src     = BSRC_CLEAR;
            cmd.cursor_clear = 1'b1;
            send_ret_nxt     = S_FINISH;
            state_nxt        = S_SEND_HI;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_PUT: begin
        cmd.byte_load = 1'b1;
        cmd.byte_src  = BSRC_DATA;
        n_nxt         = n_r + N_W'(1);
        send_ret_nxt  = S_PUT_ADV;
        state_nxt     = S_SEND_HI;
      end
      S_SEND_HI: begin
        if (sts.tx_ready) begin
          cmd.push  = 1'b1;
          state_nxt = sts.four_bit ? S_SEND_LO : send_ret_r;
        end
      end
      S_SEND_LO: begin
        if (sts.tx_ready) begin
          cmd.push   = 1'b1;
          cmd.nib_lo = 1'b1;
          state_nxt  = send_ret_r;
        end
      end
      S_PUT_ADV: begin
        cmd.col_adv = 1'b1;
        if (sts.wrap_hit) begin
          cmd.goto_load = 1'b1;
          cmd.goto_src  = GSRC_NEWLINE;
          goto_ret_nxt  = S_PUT_SPLIT;
          state_nxt     = S_GOTO;
        end else begin
          state_nxt = S_PUT_SPLIT;
        end
      end
      S_PUT_SPLIT: begin
        if (sts.split) begin
          cmd.goto_load = 1'b1;
          cmd.goto_src  = GSRC_CURSOR;
          goto_ret_nxt  = S_TAB_CHK;
          state_nxt     = S_GOTO;
        end else begin
          state_nxt = tab_more ? S_PUT : S_FINISH;
        end
      end
      S_TAB_CHK: begin
        state_nxt = tab_more ? S_PUT : S_FINISH;
      end
      S_GOTO: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_GOTO_DIV;
        end else begin
          state_nxt = S_GOTO_ADDR;
        end
      end
      S_GOTO_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_GOTO_ADDR;
        end
      end
      S_GOTO_ADDR: begin
        cmd.byte_load  = 1'b1;
        cmd.byte_src   = BSRC_ADDR;
        cmd.cursor_set = 1'b1;
        send_ret_nxt   = goto_ret_r;
        state_nxt      = S_SEND_HI;
      end
      S_FINISH: begin
        if (sts.tx_ready) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      send_ret_r <= S_IDLE;
      goto_ret_r <= S_IDLE;
      n_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      send_ret_r <= send_ret_nxt;
      goto_ret_r <= goto_ret_nxt;
      n_r        <= n_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request did not start decoding");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.push, cmd.flush, cmd.byte_load, cmd.goto_load}) <= 1)
    else $error("conflicting datapath commands");

  a_tab_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= TAB_N)
    else $error("tab space count passed its limit");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_GOTO_DIV && sts.div_busy))
    else $error("remainder unit did not start");
`endif

endmodule

`default_nettype wire

// File: hdl/char_lcd_text_to_bus_writer.sv
// Top level of the character-LCD text-to-bus writer: controller plus datapath.
// Depends on clw_pkg, clw_in_if, clw_out_if, clw_ctrl and clw_datapath.
//
//   Channel   Direction  Handshake        Carries
//   in_chan   sink       valid / ready    kind, char_code, target_row, target_col
//   out_chan  source     valid / ready    register_select, bus_value, last
//   cfg_*     sink       cfg_we only      cfg_index, cfg_data
//
// One request is worked at a time; in_chan.ready is high only while the sequencer idles.
// A plain character is sent as two nibble transfers in 4-bit mode or one in 8-bit mode;
// a move sends one address command. Each address command also waits for the
// shared remainder divider under the split or four-row layouts; a tab repeats the sequence.
// Reset is synchronous on rst_n; an output stall holds the sequencer at its next transfer.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_text_to_bus_writer import clw_pkg::*; #(
  parameter int TAB_STOP     = TAB_STOP_DEF,
  parameter int COLUMN_LIMIT = COLUMN_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  clw_in_if.sink                in_chan,
  clw_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  clw_cmd_t cmd;
  clw_sts_t sts;
  logic     in_ready;

  assign in_chan.ready = in_ready;

  clw_ctrl #(
    .TAB_STOP (TAB_STOP)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clw_datapath #(
    .TAB_STOP     (TAB_STOP),
    .COLUMN_LIMIT (COLUMN_LIMIT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_chan.kind),
    .in_char_code  (in_chan.char_code),
    .in_target_row (in_chan.target_row),
    .in_target_col (in_chan.target_col),
    .out_chan      (out_chan)
  );

endmodule

`default_nettype wire
